// ===== rtl/ats_pkg.sv =====
// ----------------------------------------------------------------------------
// ats_pkg
// Shared constants, types and the atan table for the tilt smoother.
// ----------------------------------------------------------------------------
`default_nettype none
package ats_pkg;
    localparam int AVG_DEPTH_DEF     = 8;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int TABLE_LEN         = 24;
    localparam int ANGLE_LIMIT       = 23040;
    // cordic word: r*256 up to 2^24, grows by ~1.65, plus sign
    localparam int CW = 28;
    localparam int AW = 24;

    typedef struct packed {
        logic load;      // capture sample, start square sums
        logic sqrt_step; // one root step on both magnitudes
        logic cor_init;  // load cordic vector
        logic cor_step;  // one cordic stage
        logic avg_rd;    // read ring entry
        logic avg_upd;   // update totals and ring
    } t_cmd;

    typedef struct packed {
        logic sqrt_done;
        logic cor_done;
    } t_sts;

    function automatic logic [AW-1:0] atan_lut(input logic [4:0] i);
        case (i)
            5'd0:  atan_lut = 24'd2949120;
            5'd1:  atan_lut = 24'd1740967;
            5'd2:  atan_lut = 24'd919879;
            5'd3:  atan_lut = 24'd466945;
            5'd4:  atan_lut = 24'd234379;
            5'd5:  atan_lut = 24'd117304;
            5'd6:  atan_lut = 24'd58666;
            5'd7:  atan_lut = 24'd29335;
            5'd8:  atan_lut = 24'd14668;
            5'd9:  atan_lut = 24'd7334;
            5'd10: atan_lut = 24'd3667;
            5'd11: atan_lut = 24'd1833;
            5'd12: atan_lut = 24'd917;
            5'd13: atan_lut = 24'd458;
            5'd14: atan_lut = 24'd229;
            5'd15: atan_lut = 24'd115;
            5'd16: atan_lut = 24'd57;
            5'd17: atan_lut = 24'd29;
            5'd18: atan_lut = 24'd14;
            5'd19: atan_lut = 24'd7;
            5'd20: atan_lut = 24'd4;
            5'd21: atan_lut = 24'd2;
            5'd22: atan_lut = 24'd1;
            default: atan_lut = 24'd0;
        endcase
    endfunction
endpackage
`default_nettype wire

// ===== rtl/ats_stream_if.sv =====
// ----------------------------------------------------------------------------
// ats_stream_if
// Valid/ready channel carrying a parameterized payload.
// ----------------------------------------------------------------------------
`default_nettype none
interface ats_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/ats_types.sv =====
// ----------------------------------------------------------------------------
// ats_types
// Payload structs for the tilt smoother channels.
// ----------------------------------------------------------------------------
`default_nettype none
package ats_types;
    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
    } t_in;
    typedef struct packed {
        logic signed [15:0] raw_pitch;
        logic signed [15:0] raw_roll;
        logic signed [15:0] avg_pitch;
        logic signed [15:0] avg_roll;
    } t_out;
endpackage
`default_nettype wire

// ===== rtl/accel_tilt_smoother_top.sv =====
// ----------------------------------------------------------------------------
// accel_tilt_smoother_top
// Pitch and roll from a three-axis accelerometer with boxcar smoothing.
// ----------------------------------------------------------------------------
// Usage:
//   in channel carries accel_x, accel_y, accel_z (signed 16 bit); out channel
//   carries raw_pitch, raw_roll, avg_pitch, avg_roll in 1/256 deg.
//   One result per item, valid/ready handshake on both sides.
//   Sequence: load, 16 root steps, cordic init, the cordic stages, then the
//   average read and the average update, then the result is shown.
//   One item at a time: the next item is taken the cycle after the result
//   is taken. The root and the cordic loop are iterative units that the
//   sequencer steps in turn.
//   Reset clears the history ring, totals and ring position to zero.
//   A stalled sink holds the result and the block takes no new item.
// ----------------------------------------------------------------------------
`default_nettype none
module accel_tilt_smoother_top #(
    parameter int AVG_DEPTH     = ats_pkg::AVG_DEPTH_DEF,
    parameter int CORDIC_STAGES = ats_pkg::CORDIC_STAGES_DEF
) (
    input  wire i_clk,
    input  wire i_rst_n,
    ats_stream_if.sink   in_if,
    ats_stream_if.source out_if
);
    ats_pkg::t_cmd w_cmd;
    ats_pkg::t_sts w_sts;
    logic signed [15:0] w_rp, w_rr, w_sp, w_sr;

    ats_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_if.valid),
        .o_in_ready (in_if.ready),
        .o_out_valid(out_if.valid),
        .i_out_ready(out_if.ready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    ats_datapath #(
        .AVG_DEPTH    (AVG_DEPTH),
        .CORDIC_STAGES(CORDIC_STAGES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_ax       (in_if.data.accel_x),
        .i_ay       (in_if.data.accel_y),
        .i_az       (in_if.data.accel_z),
        .o_raw_pitch(w_rp),
        .o_raw_roll (w_rr),
        .o_sm_pitch (w_sp),
        .o_sm_roll  (w_sr)
    );

    assign out_if.data.raw_pitch = w_rp;
    assign out_if.data.raw_roll  = w_rr;
    assign out_if.data.avg_pitch = w_sp;
    assign out_if.data.avg_roll  = w_sr;
endmodule
`default_nettype wire

// ===== rtl/ats_datapath.sv =====
// ----------------------------------------------------------------------------
// ats_datapath
// Square sums, shared bitwise root, dual cordic and boxcar average.
// ----------------------------------------------------------------------------
`default_nettype none
module ats_datapath #(
    parameter int AVG_DEPTH     = ats_pkg::AVG_DEPTH_DEF,
    parameter int CORDIC_STAGES = ats_pkg::CORDIC_STAGES_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  ats_pkg::t_cmd      i_cmd,
    output ats_pkg::t_sts      o_sts,
    input  wire signed [15:0]  i_ax,
    input  wire signed [15:0]  i_ay,
    input  wire signed [15:0]  i_az,
    output logic signed [15:0] o_raw_pitch,
    output logic signed [15:0] o_raw_roll,
    output logic signed [15:0] o_sm_pitch,
    output logic signed [15:0] o_sm_roll
);
    localparam int CW   = ats_pkg::CW;
    localparam int AW   = ats_pkg::AW;
    localparam int NST  = (CORDIC_STAGES > ats_pkg::TABLE_LEN) ?
                          ats_pkg::TABLE_LEN : CORDIC_STAGES;
    localparam int PW   = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int TW   = 16 + PW + 1;
    // reciprocal of the depth, exact for magnitudes below 2^(TW-1)
    localparam int          QS    = TW - 1 + PW;
    localparam int          RW    = QS + 1;
    localparam logic [63:0] RECIP = ((64'd1 << QS) + 64'(AVG_DEPTH) - 64'd1) /
                                    64'(AVG_DEPTH);

    logic signed [15:0] r_ax, r_ay;
    // root state, two magnitudes
    logic [32:0] r_rem_p, r_rem_r, n_rem_p, n_rem_r;
    logic [31:0] r_root_p, r_root_r, n_root_p, n_root_r;
    logic [3:0]  r_sq_cnt;
    logic [31:0] w_bit;
    // cordic state
    logic signed [CW-1:0] r_cx_p, r_cy_p, r_cx_r, r_cy_r;
    logic signed [AW+1:0] r_acc_p, r_acc_r;
    logic [4:0] r_st;
    logic signed [CW-1:0] n_cx_p, n_cy_p, n_cx_r, n_cy_r;
    logic signed [AW+1:0] n_acc_p, n_acc_r;
    // ring
    logic signed [15:0] r_hp [AVG_DEPTH];
    logic signed [15:0] r_hr [AVG_DEPTH];
    logic [PW-1:0] r_pos;
    logic signed [TW-1:0] r_tp, r_tr;
    logic signed [15:0] r_oldp, r_oldr;
    logic signed [15:0] w_pitch, w_roll;

    assign w_bit = 32'd1 << (5'd30 - {r_sq_cnt, 1'b0});

    // one root step, restoring, both magnitudes
    always_comb begin
        n_rem_p  = r_rem_p;
        n_root_p = r_root_p >> 1;
        if (r_rem_p >= {1'b0, r_root_p + w_bit}) begin
            n_rem_p  = r_rem_p - {1'b0, r_root_p + w_bit};
            n_root_p = (r_root_p >> 1) + w_bit;
        end
        n_rem_r  = r_rem_r;
        n_root_r = r_root_r >> 1;
        if (r_rem_r >= {1'b0, r_root_r + w_bit}) begin
            n_rem_r  = r_rem_r - {1'b0, r_root_r + w_bit};
            n_root_r = (r_root_r >> 1) + w_bit;
        end
    end

    // capture sample, squares summed, then sixteen root steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_cnt <= '0;
        end else if (i_cmd.load) begin
            r_ax     <= i_ax;
            r_ay     <= i_ay;
            r_rem_p  <= {1'b0, 32'(i_ax) * 32'(i_ax)} + {1'b0, 32'(i_az) * 32'(i_az)};
            r_rem_r  <= {1'b0, 32'(i_ay) * 32'(i_ay)} + {1'b0, 32'(i_az) * 32'(i_az)};
            r_root_p <= '0;
            r_root_r <= '0;
            r_sq_cnt <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_rem_p  <= n_rem_p;
            r_rem_r  <= n_rem_r;
            r_root_p <= n_root_p;
            r_root_r <= n_root_r;
            r_sq_cnt <= r_sq_cnt + 4'd1;
        end
    end
    assign o_sts.sqrt_done = (r_sq_cnt == 4'd15) && i_cmd.sqrt_step;

    // cordic stage, floor shifts
    always_comb begin
        n_cx_p = r_cx_p; n_cy_p = r_cy_p; n_acc_p = r_acc_p;
        n_cx_r = r_cx_r; n_cy_r = r_cy_r; n_acc_r = r_acc_r;
        if (!r_cy_p[CW-1]) begin
            n_cx_p  = r_cx_p + (r_cy_p >>> r_st);
            n_cy_p  = r_cy_p - (r_cx_p >>> r_st);
            n_acc_p = r_acc_p + $signed({2'b00, ats_pkg::atan_lut(r_st)});
        end else begin
            n_cx_p  = r_cx_p - (r_cy_p >>> r_st);
            n_cy_p  = r_cy_p + (r_cx_p >>> r_st);
            n_acc_p = r_acc_p - $signed({2'b00, ats_pkg::atan_lut(r_st)});
        end
        if (!r_cy_r[CW-1]) begin
            n_cx_r  = r_cx_r + (r_cy_r >>> r_st);
            n_cy_r  = r_cy_r - (r_cx_r >>> r_st);
            n_acc_r = r_acc_r + $signed({2'b00, ats_pkg::atan_lut(r_st)});
        end else begin
            n_cx_r  = r_cx_r - (r_cy_r >>> r_st);
            n_cy_r  = r_cy_r + (r_cx_r >>> r_st);
            n_acc_r = r_acc_r - $signed({2'b00, ats_pkg::atan_lut(r_st)});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (i_cmd.cor_init) begin
            r_cx_p  <= $signed({{(CW-24){1'b0}}, r_root_p[15:0], 8'd0});
            r_cy_p  <= $signed({{(CW-24){r_ay[15]}}, r_ay, 8'd0});
            r_cx_r  <= $signed({{(CW-24){1'b0}}, r_root_r[15:0], 8'd0});
            r_cy_r  <= $signed({{(CW-24){r_ax[15]}}, r_ax, 8'd0});
            r_acc_p <= '0;
            r_acc_r <= '0;
            r_st    <= '0;
        end else if (i_cmd.cor_step) begin
            r_cx_p <= n_cx_p; r_cy_p <= n_cy_p; r_acc_p <= n_acc_p;
            r_cx_r <= n_cx_r; r_cy_r <= n_cy_r; r_acc_r <= n_acc_r;
            r_st   <= r_st + 5'd1;
        end
    end
    assign o_sts.cor_done = (r_st == 5'(NST - 1)) && i_cmd.cor_step;

    // round, saturate, special cases
    function automatic logic signed [15:0] fin(input logic signed [15:0] a,
                                               input logic [31:0] r,
                                               input logic signed [AW+1:0] acc);
        logic signed [AW+1:0] t;
        logic signed [AW-7:0] o;
        begin
            t = acc + (AW+2)'(128);
            o = t[AW+1:8];
            if (a == 16'sd0)
                fin = 16'sd0;
            else if (r == 32'd0)
                fin = a[15] ? -16'sd23040 : 16'sd23040;
            else if (o > (AW-6)'(ats_pkg::ANGLE_LIMIT))
                fin = 16'sd23040;
            else if (o < -(AW-6)'(ats_pkg::ANGLE_LIMIT))
                fin = -16'sd23040;
            else
                fin = o[15:0];
        end
    endfunction
    assign w_pitch = fin(r_ay, r_root_p, r_acc_p);
    assign w_roll  = fin(r_ax, r_root_r, r_acc_r);

    // boxcar ring and running totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < AVG_DEPTH; k++) begin
                r_hp[k] <= '0;
                r_hr[k] <= '0;
            end
            r_pos <= '0;
            r_tp  <= '0;
            r_tr  <= '0;
        end else if (i_cmd.avg_rd) begin
            r_oldp <= r_hp[r_pos];
            r_oldr <= r_hr[r_pos];
        end else if (i_cmd.avg_upd) begin
            r_tp <= r_tp + TW'(w_pitch) - TW'(r_oldp);
            r_tr <= r_tr + TW'(w_roll) - TW'(r_oldr);
            r_hp[r_pos] <= w_pitch;
            r_hr[r_pos] <= w_roll;
            r_pos <= (r_pos == PW'(AVG_DEPTH - 1)) ? '0 : r_pos + PW'(1);
        end
    end

    // truncating divide by the depth, reciprocal multiply on the magnitude
    function automatic logic signed [15:0] avg_of(input logic signed [TW-1:0] t);
        logic [TW-1:0]    mag;
        logic [TW+RW-1:0] prod;
        logic [15:0]      q;
        begin
            mag    = t[TW-1] ? $unsigned(-t) : $unsigned(t);
            prod   = {{RW{1'b0}}, mag} * {{TW{1'b0}}, RECIP[RW-1:0]};
            q      = prod[QS +: 16];
            avg_of = t[TW-1] ? -$signed(q) : $signed(q);
        end
    endfunction

    assign o_raw_pitch = w_pitch;
    assign o_raw_roll  = w_roll;
    assign o_sm_pitch  = avg_of(r_tp);
    assign o_sm_roll   = avg_of(r_tr);
endmodule
`default_nettype wire

// ===== rtl/ats_ctrl.sv =====
// ----------------------------------------------------------------------------
// ats_ctrl
// Sequencer: root, cordic, average, then holds the result for the sink.
// ----------------------------------------------------------------------------
`default_nettype none
module ats_ctrl (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  wire           i_out_ready,
    output ats_pkg::t_cmd o_cmd,
    input  ats_pkg::t_sts i_sts
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQRT = 3'd1;
    localparam logic [2:0] S_INIT = 3'd2;
    localparam logic [2:0] S_COR  = 3'd3;
    localparam logic [2:0] S_RD   = 3'd4;
    localparam logic [2:0] S_UPD  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0] r_state, n_state;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) n_state = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (i_sts.sqrt_done) n_state = S_INIT;
            end
            S_INIT: begin
                o_cmd.cor_init = 1'b1;
                n_state = S_COR;
            end
            S_COR: begin
                o_cmd.cor_step = 1'b1;
                if (i_sts.cor_done) n_state = S_RD;
            end
            S_RD: begin
                o_cmd.avg_rd = 1'b1;
                n_state = S_UPD;
            end
            S_UPD: begin
                o_cmd.avg_upd = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef ASSERT_OFF
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd)) else $error("several commands at once");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid) else $error("result dropped");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready) else $error("accept while result pending");
    a_upd_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.avg_upd |=> o_out_valid) else $error("update not followed by result");
`endif
endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives accel samples into the tilt smoother with random gaps and sink
// stalls, predicts pitch, roll and their moving averages, and checks each
// result item in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    localparam int DEPTH     = 8;
    localparam int STAGES    = 16;
    localparam int LIMIT     = 23040;
    localparam int N_RANDOM  = 1930;
    localparam int MAX_CYC   = 2000000;

    logic i_clk;
    logic i_rst_n;
    int   cycle_cnt;
    int   err_cnt;
    bit   stim_done;
    bit   long_hold;

    ats_stream_if #(.T(ats_types::t_in))  sample_if ();
    ats_stream_if #(.T(ats_types::t_out)) angle_if ();

    accel_tilt_smoother_top #(.AVG_DEPTH(DEPTH), .CORDIC_STAGES(STAGES)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .in_if  (sample_if.sink),
        .out_if (angle_if.source)
    );

    // tilt predictor with its own history ring
    class tilt_scoreboard;
        logic signed [15:0]  pitch_ring[DEPTH];
        logic signed [15:0]  roll_ring[DEPTH];
        int                  pitch_run;
        int                  roll_run;
        int                  slot;
        ats_types::t_out     pending[$];

        function new();
            foreach (pitch_ring[i]) begin
                pitch_ring[i] = '0;
                roll_ring[i]  = '0;
            end
            pitch_run = 0;
            roll_run  = 0;
            slot      = 0;
        endfunction

        function automatic longint unsigned root_floor(longint unsigned v);
            longint unsigned r;
            r = 0;
            for (int b = 16; b >= 0; b--) begin
                if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= v)
                    r = r | (64'd1 << b);
            end
            return r;
        endfunction

        function automatic int atan_of(int num, longint mag);
            longint vx, vy, acc, nx, q;
            longint lut[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                                58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                                229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
            if (num == 0) return 0;
            if (mag == 0) return num > 0 ? LIMIT : -LIMIT;
            vx  = mag * 256;
            vy  = longint'(num) * 256;
            acc = 0;
            for (int i = 0; i < STAGES; i++) begin
                if (vy >= 0) begin
                    nx  = vx + (vy >>> i);
                    vy  = vy - (vx >>> i);
                    acc += lut[i];
                end else begin
                    nx  = vx - (vy >>> i);
                    vy  = vy + (vx >>> i);
                    acc -= lut[i];
                end
                vx = nx;
            end
            q = (acc + 128) >>> 8;
            if (q > LIMIT) q = LIMIT;
            if (q < -LIMIT) q = -LIMIT;
            return int'(q);
        endfunction

        function void note_sample(ats_types::t_in s);
            longint          ax, ay, az;
            int              p, r;
            ats_types::t_out e;
            ax = s.accel_x;
            ay = s.accel_y;
            az = s.accel_z;
            p  = atan_of(int'(ay), root_floor(ax * ax + az * az));
            r  = atan_of(int'(ax), root_floor(ay * ay + az * az));
            pitch_run += p - int'(pitch_ring[slot]);
            roll_run  += r - int'(roll_ring[slot]);
            pitch_ring[slot] = p[15:0];
            roll_ring[slot]  = r[15:0];
            slot = (slot + 1) % DEPTH;
            e.raw_pitch = p[15:0];
            e.raw_roll  = r[15:0];
            e.avg_pitch = 16'(pitch_run / DEPTH);
            e.avg_roll  = 16'(roll_run / DEPTH);
            pending.push_back(e);
        endfunction

        function int check_angles(ats_types::t_out got);
            ats_types::t_out e;
            int              bad;
            bad = 0;
            if (pending.size() == 0) begin
                $error("result item with nothing expected");
                return 1;
            end
            e = pending.pop_front();
            if (got.raw_pitch !== e.raw_pitch) begin
                $error("raw_pitch exp %0d got %0d", e.raw_pitch, got.raw_pitch);
                bad++;
            end
            if (got.raw_roll !== e.raw_roll) begin
                $error("raw_roll exp %0d got %0d", e.raw_roll, got.raw_roll);
                bad++;
            end
            if (got.avg_pitch !== e.avg_pitch) begin
                $error("avg_pitch exp %0d got %0d", e.avg_pitch, got.avg_pitch);
                bad++;
            end
            if (got.avg_roll !== e.avg_roll) begin
                $error("avg_roll exp %0d got %0d", e.avg_roll, got.avg_roll);
                bad++;
            end
            return bad;
        endfunction
    endclass

    tilt_scoreboard angle_sb;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 50) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        ats_types::t_in s;
        int             g;
        g = gap_len();
        if (long_hold) g = 0;
        repeat (g) begin
            sample_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        s.accel_x = x;
        s.accel_y = y;
        s.accel_z = z;
        sample_if.valid <= 1'b1;
        sample_if.data  <= s;
        @(posedge i_clk);
        while (!sample_if.ready) @(posedge i_clk);
        angle_sb.note_sample(s);
    endtask

    function automatic logic [15:0] pick_axis();
        int k;
        k = $urandom_range(0, 9);
        case (k)
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'(int'($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    // stimulus
    initial begin
        angle_sb        = new();
        long_hold       = 1'b0;
        stim_done       = 1'b0;
        sample_if.valid = 1'b0;
        sample_if.data  = '0;
        i_rst_n         = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, zero numerators, zero magnitudes
        send_sample(16'h0000, 16'h0000, 16'h0000);
        send_sample(16'h0000, 16'h0001, 16'h0000);
        send_sample(16'h0000, 16'hffff, 16'h0000);
        send_sample(16'h0001, 16'h0000, 16'h0000);
        send_sample(16'hffff, 16'h0000, 16'h0000);
        send_sample(16'h0000, 16'h0000, 16'h7fff);
        send_sample(16'h7fff, 16'h7fff, 16'h7fff);
        send_sample(16'h8000, 16'h8000, 16'h8000);
        send_sample(16'h8000, 16'h7fff, 16'h0000);
        send_sample(16'h7fff, 16'h8000, 16'h8000);
        send_sample(16'h0000, 16'h8000, 16'h0000);
        send_sample(16'h8000, 16'h0000, 16'h0000);
        send_sample(16'h0001, 16'h7fff, 16'h0001);
        send_sample(16'hffff, 16'hffff, 16'hffff);
        send_sample(16'h4000, 16'hc000, 16'h0100);
        send_sample(16'h0000, 16'h0000, 16'h8000);
        send_sample(16'h5555, 16'haaaa, 16'h5555);
        send_sample(16'haaaa, 16'h5555, 16'haaaa);

        // random samples, a long sink hold in the middle
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 2) long_hold = 1'b1;
            if (n == N_RANDOM / 2 + 6) long_hold = 1'b0;
            send_sample(pick_axis(), pick_axis(), pick_axis());
        end
        sample_if.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // result sink with random stalls
    initial begin
        int g;
        int held;
        angle_if.ready = 1'b0;
        held = 0;
        @(posedge i_rst_n);
        forever begin
            if (long_hold && held == 0) begin
                held = 1;
                angle_if.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end
            g = gap_len();
            if (g > 0) begin
                angle_if.ready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
            angle_if.ready <= 1'b1;
            @(posedge i_clk);
            if (angle_if.valid)
                err_cnt += angle_sb.check_angles(angle_if.data);
        end
    end

    // cycle limit
    initial begin
        cycle_cnt = 0;
        err_cnt   = 0;
        forever begin
            @(posedge i_clk);
            cycle_cnt++;
            if (cycle_cnt > MAX_CYC) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // end of run
    initial begin
        wait (stim_done);
        while (angle_sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (err_cnt == 0 && angle_sb.pending.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
